[sv/fst_pkg.sv]
package fst_pkg;

    localparam int VALUE_W = 32;
    localparam int STAT_W  = 33;
    localparam int N_STATS = 12;
    localparam int N_LATCH = 12;
    localparam int WIDE_W  = 35;

    // request kinds
    localparam logic [2:0] REQ_POS   = 3'd0;
    localparam logic [2:0] REQ_VEL   = 3'd1;
    localparam logic [2:0] REQ_GYRO  = 3'd2;
    localparam logic [2:0] REQ_AIRBAT = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    // flight tracker states
    localparam logic [1:0] FS_IDLE    = 2'd0;
    localparam logic [1:0] FS_RESET   = 2'd1;
    localparam logic [1:0] FS_COLLECT = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_BEHAVIOR = 2'd0;
    localparam logic [1:0] CFG_AIRSPEED = 2'd1;
    localparam logic [1:0] CFG_BATTERY  = 2'd2;

    localparam logic [3:0] LAST_STAT = 4'(N_STATS - 1);
    localparam logic [1:0] LAST_HYP  = 2'd2;

    typedef struct packed {
        logic       take;
        logic       capture;
        logic       hyp_start;
        logic [1:0] hyp_sel;
        logic       hyp_store;
        logic       update;
        logic       out_load;
        logic [3:0] out_idx;
    } fst_cmd_t;

    typedef struct packed {
        logic tick_collect;
        logic hyp_done;
    } fst_status_t;

endpackage

[sv/fst_hypot.sv]
module fst_hypot
    import fst_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [STAT_W-1:0] a_in,
    input  logic signed [STAT_W-1:0] b_in,
    output logic                     done,
    output logic [VALUE_W-1:0]       result
);

    typedef enum logic [2:0] {H_IDLE, H_MA, H_MB, H_ADD, H_ROOT} hstate_t;

    hstate_t               hstate_reg;
    logic [STAT_W-1:0]     ua_reg, ub_reg;
    logic                  sat_reg;
    logic [63:0]           prod_reg, acc_reg, n_reg;
    logic [33:0]           rem_reg;
    logic [VALUE_W-1:0]    root_reg;
    logic [4:0]            cnt_reg;
    logic                  done_reg;

    logic [STAT_W-1:0]     ua_next, ub_next;
    logic [64:0]           sum;
    logic [33:0]           rem_shift, trial;

    // magnitudes: -2^32 maps to 2^32, which flags saturation
    assign ua_next = a_in[STAT_W-1] ? (~a_in + 1'b1) : a_in;
    assign ub_next = b_in[STAT_W-1] ? (~b_in + 1'b1) : b_in;
    assign sum     = {1'b0, acc_reg} + {1'b0, prod_reg};

    // one root digit per cycle
    assign rem_shift = {rem_reg[31:0], n_reg[63:62]};
    assign trial     = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hstate_reg <= H_IDLE;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (hstate_reg)
                H_IDLE: begin
                    if (start) begin
                        ua_reg     <= ua_next;
                        ub_reg     <= ub_next;
                        sat_reg    <= ua_next[STAT_W-1] | ub_next[STAT_W-1];
                        hstate_reg <= H_MA;
                    end
                end
                H_MA: begin
                    prod_reg   <= ua_reg[VALUE_W-1:0] * ua_reg[VALUE_W-1:0];
                    hstate_reg <= H_MB;
                end
                H_MB: begin
                    acc_reg    <= prod_reg;
                    prod_reg   <= ub_reg[VALUE_W-1:0] * ub_reg[VALUE_W-1:0];
                    hstate_reg <= H_ADD;
                end
                H_ADD: begin
                    if (sat_reg || sum[64]) begin
                        root_reg   <= '1;
                        done_reg   <= 1'b1;
                        hstate_reg <= H_IDLE;
                    end else begin
                        n_reg      <= sum[63:0];
                        rem_reg    <= '0;
                        root_reg   <= '0;
                        cnt_reg    <= '0;
                        hstate_reg <= H_ROOT;
                    end
                end
                H_ROOT: begin
                    n_reg <= {n_reg[61:0], 2'b00};
                    if (rem_shift >= trial) begin
                        rem_reg  <= rem_shift - trial;
                        root_reg <= {root_reg[VALUE_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[VALUE_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        done_reg   <= 1'b1;
                        hstate_reg <= H_IDLE;
                    end
                end
                default: hstate_reg <= H_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = root_reg;

endmodule

[sv/fst_datapath.sv]
module fst_datapath
    import fst_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fst_cmd_t                  cmd,
    output fst_status_t               st,
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_addr,
    input  logic [0:0]                cfg_wr_data,
    input  logic [2:0]                req_type,
    input  logic signed [VALUE_W-1:0] value_x,
    input  logic signed [VALUE_W-1:0] value_y,
    input  logic signed [VALUE_W-1:0] value_z,
    input  logic                      armed,
    output logic [3:0]                stat_id,
    output logic signed [STAT_W-1:0]  stat_value,
    output logic [1:0]                machine_state,
    output logic                      last_of_run
);

    localparam logic signed [WIDE_W-1:0] LIM_HI = WIDE_W'(64'sd4294967295);
    localparam logic signed [WIDE_W-1:0] LIM_LO = -WIDE_W'(64'sd4294967296);

    logic signed [VALUE_W-1:0] lat_reg [N_LATCH];
    logic signed [VALUE_W-1:0] prev_reg [2];
    logic signed [VALUE_W-1:0] start_e_reg;
    logic signed [STAT_W-1:0]  carry_e_reg;
    logic signed [STAT_W-1:0]  stat_reg [N_STATS];
    logic [VALUE_W-1:0]        hyp_reg [3];
    logic [1:0]                fstate_reg;
    logic                      first_reg;
    logic                      armed_reg;
    logic                      mode_reg, air_reg, bat_reg;

    logic [3:0]                stat_id_reg;
    logic signed [STAT_W-1:0]  stat_value_reg;
    logic [1:0]                mstate_reg;
    logic                      last_reg;

    logic signed [STAT_W-1:0]  hyp_a, hyp_b;
    logic                      hyp_done;
    logic [VALUE_W-1:0]        hyp_res;
    logic [3:0]                base;

    function automatic logic signed [WIDE_W-1:0] wide(input logic signed [VALUE_W-1:0] v);
        return WIDE_W'(v);
    endfunction

    function automatic logic signed [WIDE_W-1:0] wstat(input logic signed [STAT_W-1:0] v);
        return WIDE_W'(v);
    endfunction

    function automatic logic signed [WIDE_W-1:0] smax(input logic signed [WIDE_W-1:0] a,
                                                      input logic signed [WIDE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [STAT_W-1:0] clamp(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > LIM_HI) r = LIM_HI;
        if (v < LIM_LO) r = LIM_LO;
        return r[STAT_W-1:0];
    endfunction

    function automatic logic signed [WIDE_W-1:0] wmag(input logic signed [VALUE_W-1:0] v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return (w < 0) ? -w : w;
    endfunction

    assign st.tick_collect = (req_type == REQ_TICK) && (fstate_reg == FS_COLLECT);
    assign st.hyp_done     = hyp_done;

    // hypot operand select
    always_comb begin
        case (cmd.hyp_sel)
            2'd0: begin
                hyp_a = STAT_W'(lat_reg[0]) - STAT_W'(prev_reg[0]);
                hyp_b = STAT_W'(lat_reg[1]) - STAT_W'(prev_reg[1]);
            end
            2'd1: begin
                hyp_a = STAT_W'(lat_reg[0]);
                hyp_b = STAT_W'(lat_reg[1]);
            end
            default: begin
                hyp_a = STAT_W'(lat_reg[3]);
                hyp_b = STAT_W'(lat_reg[4]);
            end
        endcase
    end

    fst_hypot u_hypot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.hyp_start),
        .a_in    (hyp_a),
        .b_in    (hyp_b),
        .done    (hyp_done),
        .result  (hyp_res)
    );

    assign base = 4'(req_type[1:0]) * 4'd3;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            air_reg  <= 1'b0;
            bat_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BEHAVIOR: mode_reg <= cfg_wr_data[0];
                CFG_AIRSPEED: air_reg  <= cfg_wr_data[0];
                CFG_BATTERY:  bat_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // tracker state, latches and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg  <= FS_IDLE;
            first_reg   <= 1'b1;
            armed_reg   <= 1'b0;
            start_e_reg <= '0;
            carry_e_reg <= '0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
            for (int i = 0; i < N_LATCH; i++) lat_reg[i] <= '0;
            for (int i = 0; i < N_STATS; i++) stat_reg[i] <= '0;
        end else begin
            if (cmd.take) begin
                if (req_type < REQ_TICK) begin
                    lat_reg[base]        <= value_x;
                    lat_reg[base + 4'd1] <= value_y;
                    lat_reg[base + 4'd2] <= value_z;
                end else if (req_type == REQ_TICK) begin
                    armed_reg <= armed;
                    case (fstate_reg)
                        FS_IDLE: begin
                            if (armed) begin
                                fstate_reg <= mode_reg ? FS_RESET : FS_COLLECT;
                                first_reg  <= 1'b1;
                            end
                        end
                        FS_RESET: begin
                            for (int i = 0; i < N_STATS; i++) stat_reg[i] <= '0;
                            fstate_reg <= FS_COLLECT;
                        end
                        default: ;
                    endcase
                end
            end

            // first collecting tick: start captures
            if (cmd.capture && first_reg) begin
                prev_reg[0] <= lat_reg[0];
                prev_reg[1] <= lat_reg[1];
                if (bat_reg) begin
                    start_e_reg <= lat_reg[10];
                    carry_e_reg <= mode_reg ? '0 : stat_reg[10];
                    if (mode_reg || stat_reg[11] == '0)
                        stat_reg[11] <= STAT_W'(lat_reg[11]);
                end
                first_reg <= 1'b0;
            end

            if (cmd.hyp_store) hyp_reg[cmd.hyp_sel] <= hyp_res;

            // statistics update
            if (cmd.update) begin
                if (wstat(stat_reg[0]) + WIDE_W'(hyp_reg[0]) > LIM_HI)
                    stat_reg[0] <= LIM_HI[STAT_W-1:0];
                else
                    stat_reg[0] <= stat_reg[0] + STAT_W'(hyp_reg[0]);
                stat_reg[1] <= clamp(smax(wstat(stat_reg[1]), WIDE_W'(hyp_reg[1])));
                stat_reg[2] <= clamp(smax(wstat(stat_reg[2]), -wide(lat_reg[2])));
                stat_reg[3] <= clamp(smax(wstat(stat_reg[3]), WIDE_W'(hyp_reg[2])));
                stat_reg[4] <= clamp(smax(wstat(stat_reg[4]), -wide(lat_reg[5])));
                stat_reg[5] <= clamp(smax(wstat(stat_reg[5]), wide(lat_reg[5])));
                if (air_reg)
                    stat_reg[6] <= clamp(smax(wstat(stat_reg[6]), wide(lat_reg[9])));
                stat_reg[7] <= clamp(smax(wstat(stat_reg[7]), wmag(lat_reg[7])));
                stat_reg[8] <= clamp(smax(wstat(stat_reg[8]), wmag(lat_reg[6])));
                stat_reg[9] <= clamp(smax(wstat(stat_reg[9]), wmag(lat_reg[8])));
                if (bat_reg)
                    stat_reg[10] <= clamp(wstat(carry_e_reg) + wide(lat_reg[10])
                                          - wide(start_e_reg));
                prev_reg[0] <= lat_reg[0];
                prev_reg[1] <= lat_reg[1];
                if (!armed_reg) fstate_reg <= FS_IDLE;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            stat_id_reg    <= cmd.out_idx;
            stat_value_reg <= stat_reg[cmd.out_idx];
            mstate_reg     <= fstate_reg;
            last_reg       <= (cmd.out_idx == LAST_STAT);
        end
    end

    assign stat_id       = stat_id_reg;
    assign stat_value    = stat_value_reg;
    assign machine_state = mstate_reg;
    assign last_of_run   = last_reg;

endmodule

[sv/fst_ctrl.sv]
module fst_ctrl
    import fst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  fst_status_t st,
    output fst_cmd_t    cmd
);

    typedef enum logic [2:0] {
        C_IDLE, C_CAPTURE, C_HYP_GO, C_HYP_WAIT, C_UPDATE, C_LOAD, C_EMIT
    } cstate_t;

    cstate_t    state_reg;
    logic [1:0] hidx_reg;
    logic [3:0] oidx_reg;
    logic       mvalid_reg;

    assign s_tready = (state_reg == C_IDLE);
    assign m_tvalid = mvalid_reg;

    // commands
    always_comb begin
        cmd           = '0;
        cmd.take      = s_tvalid && (state_reg == C_IDLE);
        cmd.capture   = (state_reg == C_CAPTURE);
        cmd.hyp_start = (state_reg == C_HYP_GO);
        cmd.hyp_sel   = hidx_reg;
        cmd.hyp_store = (state_reg == C_HYP_WAIT) && st.hyp_done;
        cmd.update    = (state_reg == C_UPDATE);
        cmd.out_load  = (state_reg == C_LOAD);
        cmd.out_idx   = oidx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= C_IDLE;
            hidx_reg   <= '0;
            oidx_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (s_tvalid && st.tick_collect) state_reg <= C_CAPTURE;
                end
                C_CAPTURE: begin
                    hidx_reg  <= '0;
                    state_reg <= C_HYP_GO;
                end
                C_HYP_GO: state_reg <= C_HYP_WAIT;
                C_HYP_WAIT: begin
                    if (st.hyp_done) begin
                        if (hidx_reg == LAST_HYP) begin
                            state_reg <= C_UPDATE;
                        end else begin
                            hidx_reg  <= hidx_reg + 2'd1;
                            state_reg <= C_HYP_GO;
                        end
                    end
                end
                C_UPDATE: begin
                    oidx_reg  <= '0;
                    state_reg <= C_LOAD;
                end
                C_LOAD: begin
                    mvalid_reg <= 1'b1;
                    state_reg  <= C_EMIT;
                end
                C_EMIT: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        if (oidx_reg == LAST_STAT) begin
                            state_reg <= C_IDLE;
                        end else begin
                            oidx_reg  <= oidx_reg + 4'd1;
                            state_reg <= C_LOAD;
                        end
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while result pending");

    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == C_EMIT)) else $error("result valid outside emit");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st.hyp_done |-> (state_reg == C_HYP_WAIT)) else $error("hypot done unexpected");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_LOAD) |=> m_tvalid) else $error("loaded result not shown");

endmodule

[sv/flight_statistics_tracker_core.sv]
// Channel  Handshake             Payload
// s_       s_tvalid/s_tready     tuser: req_type; tdata: value_x, value_y, value_z, armed
// m_       m_tvalid/m_tready     tuser: stat_id; tdata: stat_value, machine_state; tlast
// cfg_     cfg_wr_en             cfg_addr: register index; cfg_wr_data: value
//
// Sample requests, and ticks in idle or reset state, are taken in the idle state.
// A collecting tick runs three hypotenuse passes on one shared unit (each:
// start, two multiplies, an add, a 32-step root skipped on saturation, and
// the done handoff), then emits 12 results. Reset is synchronous on aresetn;
// no clearing pass. Input is held off while a collecting tick is processed;
// output stalls hold the current result.
module flight_statistics_tracker_core
    import fst_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // value_x[31:0], value_y[63:32], value_z[95:64], armed[96]
    input  logic [2:0]   s_tuser,   // req_type[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // stat_value[32:0], machine_state[34:33]
    output logic [3:0]   m_tuser,   // stat_id[3:0]
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [0:0]   cfg_wr_data
);

    fst_cmd_t                 cmd;
    fst_status_t              st;
    logic signed [STAT_W-1:0] stat_value;
    logic [1:0]               machine_state;

    fst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fst_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .req_type      (s_tuser),
        .value_x       (s_tdata[31:0]),
        .value_y       (s_tdata[63:32]),
        .value_z       (s_tdata[95:64]),
        .armed         (s_tdata[96]),
        .stat_id       (m_tuser),
        .stat_value    (stat_value),
        .machine_state (machine_state),
        .last_of_run   (m_tlast)
    );

    assign m_tdata = {5'b0, machine_state, stat_value};

endmodule
